// File: sv/mesh_node_table_with_aging_macros.svh
// assertion macros for the node table
`ifndef MESH_NODE_TABLE_WITH_AGING_MACROS_SVH
`define MESH_NODE_TABLE_WITH_AGING_MACROS_SVH
`ifndef SYNTHESIS
`define MNT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MNT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MNT_ASSERT(name, clk, rst, prop, msg)
`define MNT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: sv/mnt_pkg.sv
package mnt_pkg;

   localparam logic [1:0] OP_ENROLL  = 2'd0;
   localparam logic [1:0] OP_REFRESH = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic [2:0] ST_UPDATED   = 3'd0;
   localparam logic [2:0] ST_INSERTED  = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_REFRESHED = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_TICK_DONE = 3'd5;
   localparam logic [2:0] ST_IGNORED   = 3'd6;

   localparam logic [2:0] ROLE_DETACHED = 3'd1;
   localparam logic [2:0] ROLE_CHILD    = 3'd2;
   localparam logic [2:0] ROLE_ROUTER   = 3'd3;

   localparam logic [31:0] KEEP_VERSION = 32'hFFFF_FFFF;

   localparam logic [2:0] CLS_FREE     = 3'd0;
   localparam logic [2:0] CLS_ROUTER   = 3'd1;
   localparam logic [2:0] CLS_CHILD    = 3'd2;
   localparam logic [2:0] CLS_DETACHED = 3'd3;
   localparam logic [2:0] CLS_OTHER    = 3'd4;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [63:0]        ext_address;
      logic [2:0]         node_role;
      logic [15:0]        parent_loc;
      logic [15:0]        node_rloc;
      logic signed [7:0]  link_rssi;
      logic [31:0]        firmware_version;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [8:0] slot;
      logic [9:0] expired_count;
      logic [9:0] router_count;
      logic [9:0] child_count;
      logic [9:0] detached_count;
      logic [9:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic        used;
      logic [63:0] ext_address;
      logic [2:0]  role;
      logic [15:0] parent;
      logic [15:0] locator;
      logic [7:0]  rssi;
      logic [31:0] version;
      logic [15:0] lifetime;
   } entry_type;

   function automatic logic [2:0] entry_class(logic used, logic [2:0] role);
      logic [2:0] c;
      if (!used) begin
         c = CLS_FREE;
      end else begin
         case (role)
            ROLE_ROUTER:   c = CLS_ROUTER;
            ROLE_CHILD:    c = CLS_CHILD;
            ROLE_DETACHED: c = CLS_DETACHED;
            default:       c = CLS_OTHER;
         endcase
      end
      return c;
   endfunction

endpackage

// File: sv/mesh_node_table_with_aging.sv
// Node table of ROUTER_SLOTS + CHILD_SLOTS entries kept in one single-port-write,
// registered-read memory. After reset the table is cleared one entry per cycle
// and no transaction is taken until then. Each enroll, refresh or tick is a
// linear pass over the memory at one entry per cycle; an enroll that inserts or
// finds its zone full then makes a second pass over its zone.
// Role and free counts are kept in counters updated on every write-back, so
// every response carries them with no extra pass. One transaction is processed
// at a time; a response waiting in the output register does not block accepting
// the next request.
`include "mesh_node_table_with_aging_macros.svh"
module mesh_node_table_with_aging
   import mnt_pkg::*;
#(
   parameter int ROUTER_SLOTS = 32,
   parameter int CHILD_SLOTS  = 480
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);

   localparam int TABLE_SLOTS = ROUTER_SLOTS + CHILD_SLOTS;
   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int CNT_W = $clog2(TABLE_SLOTS + 1);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FIND  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam logic [IDX_W:0]   TABLE_END = (IDX_W + 1)'(TABLE_SLOTS);
   localparam logic [IDX_W:0]   ROUTER_END = (IDX_W + 1)'(ROUTER_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SLOTS - 1);

   entry_type mem [TABLE_SLOTS];
   entry_type mem_q;

   logic [2:0]       state_ff, state_in;
   req_type          req_ff;
   logic [15:0]      reload_ff;
   logic [IDX_W:0]   rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] p_idx_ff;
   logic             p_valid_ff, p_valid_in;
   logic [2:0]       status_ff, status_in;
   logic [IDX_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0] expired_ff, expired_in;
   logic [CNT_W-1:0] router_ff, child_ff, detached_ff, free_ff;
   logic [CNT_W-1:0] router_in, child_in, detached_in, free_in;
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   logic             rd_en, wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   entry_type        wr_data;
   logic             as_router, in_router_zone, finish, go_find;
   logic [IDX_W:0]   scan_end, find_lo;
   logic [2:0]       old_cls, new_cls;

   function automatic logic [9:0] cnt10(logic [CNT_W-1:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[9:0];
   endfunction

   function automatic logic [8:0] slot9(logic [IDX_W-1:0] v);
      logic [31:0] t;
      t = 32'(v);
      return t[8:0];
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign as_router      = (req_ff.node_role == ROLE_ROUTER);
   assign in_router_zone = ({1'b0, p_idx_ff} < ROUTER_END);
   assign find_lo        = as_router ? '0 : ROUTER_END;
   assign scan_end       = (state_ff == S_FIND && as_router) ? ROUTER_END : TABLE_END;
   assign rd_addr        = rd_idx_ff[IDX_W-1:0];

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = p_idx_ff;
      wr_data    = mem_q;
      finish     = 1'b0;
      go_find    = 1'b0;
      status_in  = status_ff;
      slot_in    = slot_ff;
      expired_in = expired_ff;
      if (state_ff == S_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = rd_addr;
         wr_data = '0;
      end else if (state_ff == S_SCAN && p_valid_ff) begin
         case (req_ff.opcode)
            OP_ENROLL: begin
               if (mem_q.used && mem_q.ext_address == req_ff.ext_address &&
                   in_router_zone != as_router) begin
                  wr_en        = 1'b1;
                  wr_data.used = 1'b0;
                  go_find      = (p_idx_ff == LAST_IDX);
               end else if (mem_q.used && mem_q.ext_address == req_ff.ext_address) begin
                  wr_en            = 1'b1;
                  wr_data.parent   = req_ff.parent_loc;
                  wr_data.role     = req_ff.node_role;
                  wr_data.locator  = req_ff.node_rloc;
                  wr_data.rssi     = unsigned'(req_ff.link_rssi);
                  wr_data.lifetime = reload_ff;
                  if (req_ff.firmware_version != KEEP_VERSION) begin
                     wr_data.version = req_ff.firmware_version;
                  end
                  finish    = 1'b1;
                  status_in = ST_UPDATED;
                  slot_in   = p_idx_ff;
               end else begin
                  go_find = (p_idx_ff == LAST_IDX);
               end
            end
            OP_REFRESH: begin
               if (mem_q.used && mem_q.locator == req_ff.node_rloc) begin
                  wr_en            = 1'b1;
                  wr_data.role     = req_ff.node_role;
                  wr_data.parent   = req_ff.parent_loc;
                  wr_data.rssi     = unsigned'(req_ff.link_rssi);
                  wr_data.lifetime = reload_ff;
                  finish    = 1'b1;
                  status_in = ST_REFRESHED;
                  slot_in   = p_idx_ff;
               end else if (p_idx_ff == LAST_IDX) begin
                  finish    = 1'b1;
                  status_in = ST_NOT_FOUND;
               end
            end
            default: begin
               if (mem_q.used && mem_q.lifetime != 16'd0) begin
                  wr_en            = 1'b1;
                  wr_data.lifetime = mem_q.lifetime - 16'd1;
                  if (mem_q.lifetime == 16'd1) begin
                     wr_data.role = ROLE_DETACHED;
                     expired_in   = expired_ff + CNT_W'(1);
                  end
               end
               if (p_idx_ff == LAST_IDX) begin
                  finish    = 1'b1;
                  status_in = ST_TICK_DONE;
               end
            end
         endcase
      end else if (state_ff == S_FIND && p_valid_ff) begin
         if (!mem_q.used) begin
            wr_en     = 1'b1;
            wr_data   = '{used: 1'b1, ext_address: req_ff.ext_address,
                          role: req_ff.node_role, parent: req_ff.parent_loc,
                          locator: req_ff.node_rloc,
                          rssi: unsigned'(req_ff.link_rssi),
                          version: req_ff.firmware_version, lifetime: reload_ff};
            finish    = 1'b1;
            status_in = ST_INSERTED;
            slot_in   = p_idx_ff;
         end else if ({1'b0, p_idx_ff} == scan_end - 1'b1) begin
            finish    = 1'b1;
            status_in = ST_FULL;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      rd_idx_in  = rd_idx_ff;
      rd_en      = 1'b0;
      p_valid_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            rd_idx_in = rd_idx_ff + 1'b1;
            if (rd_idx_ff == TABLE_END - 1'b1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_idx_in = '0;
            if (req_valid) begin
               state_in = (req_data.opcode inside {OP_ENROLL, OP_REFRESH, OP_TICK}) ?
                          S_SCAN : S_DONE;
            end
         end
         S_SCAN, S_FIND: begin
            if (finish) begin
               state_in = S_DONE;
            end else if (go_find) begin
               state_in  = S_FIND;
               rd_idx_in = find_lo;
            end else if (rd_idx_ff < scan_end) begin
               rd_en      = 1'b1;
               p_valid_in = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      old_cls     = entry_class(mem_q.used, mem_q.role);
      new_cls     = entry_class(wr_data.used, wr_data.role);
      router_in   = router_ff;
      child_in    = child_ff;
      detached_in = detached_ff;
      free_in     = free_ff;
      if (wr_en && state_ff != S_CLEAR) begin
         router_in   = router_ff + CNT_W'(new_cls == CLS_ROUTER) -
                       CNT_W'(old_cls == CLS_ROUTER);
         child_in    = child_ff + CNT_W'(new_cls == CLS_CHILD) -
                       CNT_W'(old_cls == CLS_CHILD);
         detached_in = detached_ff + CNT_W'(new_cls == CLS_DETACHED) -
                       CNT_W'(old_cls == CLS_DETACHED);
         free_in     = free_ff + CNT_W'(new_cls == CLS_FREE) -
                       CNT_W'(old_cls == CLS_FREE);
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rd_idx_ff    <= '0;
         p_valid_ff   <= 1'b0;
         reload_ff    <= 16'd60;
         rsp_valid_ff <= 1'b0;
         router_ff    <= '0;
         child_ff     <= '0;
         detached_ff  <= '0;
         free_ff      <= CNT_W'(TABLE_SLOTS);
      end else begin
         state_ff    <= state_in;
         rd_idx_ff   <= rd_idx_in;
         p_valid_ff  <= p_valid_in;
         router_ff   <= router_in;
         child_ff    <= child_in;
         detached_ff <= detached_in;
         free_ff     <= free_in;
         if (csr_we) begin
            reload_ff <= csr_wdata;
         end
         if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      p_idx_ff <= rd_addr;
      if (state_ff == S_IDLE) begin
         req_ff     <= req_data;
         status_ff  <= ST_IGNORED;
         slot_ff    <= '0;
         expired_ff <= '0;
      end else begin
         status_ff  <= status_in;
         slot_ff    <= slot_in;
         expired_ff <= expired_in;
      end
      if (state_ff == S_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_ff <= '{status: status_ff, slot: slot9(slot_ff),
                     expired_count: cnt10(expired_ff), router_count: cnt10(router_ff),
                     child_count: cnt10(child_ff), detached_count: cnt10(detached_ff),
                     free_count: cnt10(free_ff)};
      end
   end

   `MNT_ASSERT(a_no_accept_in_clear, clock, reset, state_ff == S_CLEAR |-> !req_ready, "request taken during table clear")
   `MNT_ASSERT(a_no_same_addr, clock, reset, (rd_en && wr_en) |-> (rd_addr != wr_addr), "read and write hit the same entry")
   `MNT_ASSERT(a_counts_bounded, clock, reset, state_ff != S_CLEAR |-> ((CNT_W + 2)'(free_ff) + (CNT_W + 2)'(router_ff) + (CNT_W + 2)'(child_ff) + (CNT_W + 2)'(detached_ff) <= (CNT_W + 2)'(TABLE_SLOTS)), "role counts exceed table size")
   `MNT_ASSERT(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "response raised outside completion")

endmodule

// File: test/mesh_node_table_with_aging_test.sv
module mesh_node_table_with_aging_test;
   import mnt_pkg::*;

   localparam int ROUTERS = 32;
   localparam int SLOTS = 512;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;
   localparam int HOLD_CYCLES = 3000;
   localparam int ROWS = 14;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } row_type;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_data;
   logic    csr_we = 0;
   logic [15:0] csr_wdata = '0;

   entry_type node_tab [SLOTS];
   logic [15:0] reload_value;
   rsp_type pending_rsp [$];
   logic [63:0] addr_pool [48];
   row_type rows [ROWS];
   int errors = 0;
   int idle_cycles = 0;
   bit hold_off = 0;
   int sent_count = 0;

   mesh_node_table_with_aging i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function automatic rsp_type table_outcome(req_type r);
      rsp_type o;
      bit as_router;
      bit done;
      int lo;
      int hi;
      o = '0;
      done = 0;
      case (r.opcode)
         OP_ENROLL: begin
            as_router = (r.node_role == ROLE_ROUTER);
            for (int i = 0; i < SLOTS && !done; i++) begin
               if (node_tab[i].used && node_tab[i].ext_address == r.ext_address) begin
                  if ((i < ROUTERS) != as_router) begin
                     node_tab[i].used = 0;
                  end else begin
                     node_tab[i].parent = r.parent_loc;
                     node_tab[i].role = r.node_role;
                     node_tab[i].locator = r.node_rloc;
                     node_tab[i].rssi = r.link_rssi;
                     if (r.firmware_version != KEEP_VERSION) begin
                        node_tab[i].version = r.firmware_version;
                     end
                     node_tab[i].lifetime = reload_value;
                     o.status = ST_UPDATED;
                     o.slot = 9'(i);
                     done = 1;
                  end
               end
            end
            if (!done) begin
               lo = as_router ? 0 : ROUTERS;
               hi = as_router ? ROUTERS : SLOTS;
               o.status = ST_FULL;
               for (int i = lo; i < hi && !done; i++) begin
                  if (!node_tab[i].used) begin
                     node_tab[i].used = 1;
                     node_tab[i].ext_address = r.ext_address;
                     node_tab[i].role = r.node_role;
                     node_tab[i].parent = r.parent_loc;
                     node_tab[i].locator = r.node_rloc;
                     node_tab[i].rssi = r.link_rssi;
                     node_tab[i].version = r.firmware_version;
                     node_tab[i].lifetime = reload_value;
                     o.status = ST_INSERTED;
                     o.slot = 9'(i);
                     done = 1;
                  end
               end
            end
         end
         OP_REFRESH: begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < SLOTS && !done; i++) begin
               if (node_tab[i].used && node_tab[i].locator == r.node_rloc) begin
                  node_tab[i].role = r.node_role;
                  node_tab[i].parent = r.parent_loc;
                  node_tab[i].rssi = r.link_rssi;
                  node_tab[i].lifetime = reload_value;
                  o.status = ST_REFRESHED;
                  o.slot = 9'(i);
                  done = 1;
               end
            end
         end
         OP_TICK: begin
            o.status = ST_TICK_DONE;
            for (int i = 0; i < SLOTS; i++) begin
               if (node_tab[i].used && node_tab[i].lifetime != 16'd0) begin
                  node_tab[i].lifetime = node_tab[i].lifetime - 16'd1;
                  if (node_tab[i].lifetime == 16'd0) begin
                     node_tab[i].role = ROLE_DETACHED;
                     o.expired_count = o.expired_count + 10'd1;
                  end
               end
            end
         end
         default: o.status = ST_IGNORED;
      endcase
      for (int i = 0; i < SLOTS; i++) begin
         if (!node_tab[i].used) begin
            o.free_count = o.free_count + 10'd1;
         end else if (node_tab[i].role == ROLE_ROUTER) begin
            o.router_count = o.router_count + 10'd1;
         end else if (node_tab[i].role == ROLE_CHILD) begin
            o.child_count = o.child_count + 10'd1;
         end else if (node_tab[i].role == ROLE_DETACHED) begin
            o.detached_count = o.detached_count + 10'd1;
         end
      end
      return o;
   endfunction

   task automatic report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   function automatic int draw_gap(int n);
      return (n % 64 < 16) ? 0 : $urandom_range(0, 11);
   endfunction

   task automatic send(req_type r, bit typed, rsp_type want);
      int gap;
      rsp_type guess;
      gap = draw_gap(sent_count);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      guess = table_outcome(r);
      pending_rsp.push_back(typed ? want : guess);
      sent_count++;
   endtask

   task automatic drain;
      req_valid <= 0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_reload(logic [15:0] v);
      drain();
      csr_we <= 1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      reload_value = v;
   endtask

   function automatic req_type random_request(bit fill);
      req_type r;
      int pick;
      pick = $urandom_range(0, 99);
      r.ext_address = addr_pool[$urandom_range(0, 47)];
      r.node_role = $urandom_range(0, 1) ? ($urandom_range(0, 1) ? ROLE_ROUTER : ROLE_CHILD)
                                          : 3'($urandom_range(0, 7));
      r.parent_loc = 16'($urandom);
      r.node_rloc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
      r.link_rssi = 8'($urandom);
      r.firmware_version = ($urandom_range(0, 3) == 0) ? KEEP_VERSION : 32'($urandom);
      if (fill) begin
         if (pick < 95) begin
            r.opcode = OP_ENROLL;
            r.ext_address = {$urandom, $urandom};
            r.node_role = ($urandom_range(0, 9) == 0) ? ROLE_ROUTER : 3'($urandom_range(0, 7));
         end else begin
            r.opcode = 2'($urandom_range(0, 3));
         end
      end else begin
         r.opcode = (pick < 50) ? OP_ENROLL : (pick < 75) ? OP_REFRESH
                    : (pick < 95) ? OP_TICK : OP_UNUSED;
      end
      return r;
   endfunction

   function automatic req_type make_req(logic [1:0] op, logic [63:0] ext, logic [2:0] role,
                                        logic [15:0] parent, logic [15:0] rloc,
                                        logic [7:0] rssi, logic [31:0] ver);
      req_type r;
      r.opcode = op;
      r.ext_address = ext;
      r.node_role = role;
      r.parent_loc = parent;
      r.node_rloc = rloc;
      r.link_rssi = rssi;
      r.firmware_version = ver;
      return r;
   endfunction

   function automatic rsp_type make_rsp(logic [2:0] st, logic [8:0] slot, int rt, int ch,
                                        int fr);
      rsp_type o;
      o = '0;
      o.status = st;
      o.slot = slot;
      o.router_count = 10'(rt);
      o.child_count = 10'(ch);
      o.free_count = 10'(fr);
      return o;
   endfunction

   // receiver side
   initial begin
      int gap;
      int n;
      rsp_type want;
      n = 0;
      @(negedge reset);
      forever begin
         gap = hold_off ? HOLD_CYCLES : draw_gap(n + 40);
         hold_off = 0;
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         n++;
         if (pending_rsp.size() == 0) begin
            report("unexpected transaction status", rsp_data.status, -1);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_data.status !== want.status)
               report("status", rsp_data.status, want.status);
            if (rsp_data.slot !== want.slot)
               report("slot", rsp_data.slot, want.slot);
            if (rsp_data.expired_count !== want.expired_count)
               report("expired_count", rsp_data.expired_count, want.expired_count);
            if (rsp_data.router_count !== want.router_count)
               report("router_count", rsp_data.router_count, want.router_count);
            if (rsp_data.child_count !== want.child_count)
               report("child_count", rsp_data.child_count, want.child_count);
            if (rsp_data.detached_count !== want.detached_count)
               report("detached_count", rsp_data.detached_count, want.detached_count);
            if (rsp_data.free_count !== want.free_count)
               report("free_count", rsp_data.free_count, want.free_count);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("mesh_node_table_with_aging regression: fail");
            $finish;
         end
      end
   end

   initial begin
      rsp_type none;
      none = '0;
      reload_value = 60;
      for (int i = 0; i < SLOTS; i++) node_tab[i] = '0;
      for (int i = 0; i < 48; i++) addr_pool[i] = {$urandom, $urandom};
      addr_pool[0] = '0;
      addr_pool[1] = '1;

      rows[0] = '{make_req(OP_TICK, '0, '0, '0, '0, '0, '0), 1,
                  make_rsp(ST_TICK_DONE, 0, 0, 0, 512)};
      rows[1] = '{make_req(OP_REFRESH, '0, '0, '0, '0, '0, '0), 1,
                  make_rsp(ST_NOT_FOUND, 0, 0, 0, 512)};
      rows[2] = '{make_req(OP_UNUSED, '1, '1, '1, '1, '1, '1), 1,
                  make_rsp(ST_IGNORED, 0, 0, 0, 512)};
      rows[3] = '{make_req(OP_ENROLL, '0, ROLE_ROUTER, '0, '0, '0, '0), 1,
                  make_rsp(ST_INSERTED, 0, 1, 0, 511)};
      rows[4] = '{make_req(OP_ENROLL, '1, ROLE_CHILD, '1, '1, 8'h80, KEEP_VERSION), 1,
                  make_rsp(ST_INSERTED, 32, 1, 1, 510)};
      rows[5] = '{make_req(OP_ENROLL, '0, ROLE_ROUTER, 16'h1234, 16'h0042, 8'h7f,
                           KEEP_VERSION), 0, none};
      rows[6] = '{make_req(OP_ENROLL, '0, ROLE_CHILD, 16'h0001, 16'h0043, 8'h01, 32'h1), 0,
                  none};
      rows[7] = '{make_req(OP_ENROLL, 64'h1, 3'd4, 16'h0002, 16'h0100, 8'hf0, 32'h2), 0, none};
      rows[8] = '{make_req(OP_ENROLL, 64'h2, 3'd0, 16'h0003, 16'h0200, 8'h0f, 32'h3), 0, none};
      rows[9] = '{make_req(OP_ENROLL, 64'h3, 3'd7, 16'h0004, 16'h0300, 8'h55, 32'h4), 0, none};
      rows[10] = '{make_req(OP_REFRESH, '0, ROLE_ROUTER, 16'hbeef, 16'hffff, 8'haa, '0), 0,
                   none};
      rows[11] = '{make_req(OP_REFRESH, '0, ROLE_CHILD, '0, 16'h1234, '0, '0), 0, none};
      rows[12] = '{make_req(OP_ENROLL, 64'h4, ROLE_DETACHED, '0, 16'h0400, '0, '0), 0, none};
      rows[13] = '{make_req(OP_TICK, '0, '0, '0, '0, '0, '0), 0, none};

      repeat (6) @(posedge clock);
      reset <= 0;

      for (int i = 0; i < ROWS; i++) send(rows[i].req, rows[i].typed, rows[i].want);

      write_reload(16'd1);
      for (int i = 0; i < 80; i++) begin
         if (i == 30) hold_off = 1;
         send(random_request(0), 0, none);
      end
      write_reload(16'd4);
      for (int i = 0; i < 80; i++) send(random_request(0), 0, none);
      write_reload(16'd65535);
      for (int i = 0; i < 366; i++) send(random_request(1), 0, none);

      drain();
      repeat (50) @(posedge clock);
      if (errors == 0) begin
         $display("mesh_node_table_with_aging regression: pass");
      end else begin
         $display("mesh_node_table_with_aging regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/mnt_pkg.sv
sv/mesh_node_table_with_aging.sv
test/mesh_node_table_with_aging_test.sv
